### src/hbp_pkg.sv
package hbp_pkg;

	localparam int SYM_W        = 8;
	localparam int CODE_W       = 32;
	localparam int LEN_IN_W     = 6;
	localparam int BYTE_W       = 8;
	localparam int TABLE_DEPTH  = 256;
	localparam int MAX_CODE_LEN_DEF = 32;
	localparam int QUEUE_DEPTH  = 4;

	// request codes
	localparam logic [1:0] REQ_ENCODE = 2'd0;
	localparam logic [1:0] REQ_LOAD   = 2'd1;
	localparam logic [1:0] REQ_FLUSH  = 2'd2;

	typedef struct packed {
		logic [1:0]          req_type;
		logic [SYM_W-1:0]    symbol;
		logic [CODE_W-1:0]   code_bits;
		logic [LEN_IN_W-1:0] code_len;
	} req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last;
	} rsp_t;

endpackage

### src/hbp_ram.sv
module hbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/hbp_front.sv
module hbp_front #(
	parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  hbp_pkg::req_t req,
	output logic          req_stall,
	input  logic          q_ready,
	output logic          q_push,
	output logic [hbp_pkg::CODE_W+$clog2(MAX_CODE_LEN+1):0] q_data
);

	import hbp_pkg::*;

	localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
	localparam int ENT_W = CODE_W + LEN_W;

	logic             accept;
	logic             is_enc;
	logic             is_load;
	logic             is_flush;
	logic [LEN_W-1:0] len_sat;
	logic [ENT_W-1:0] rdata;
	logic [CODE_W-1:0] code_r;
	logic [LEN_W-1:0] len_r;
	logic [LEN_W-1:0] len_eff;
	logic [CODE_W-1:0] mask;

	logic [TABLE_DEPTH-1:0] tvld_q;
	logic vld_s1;
	logic flush_s1;
	logic hit_s1;

	assign accept   = req_valid && !req_stall;
	assign is_enc   = (req.req_type == REQ_ENCODE);
	assign is_load  = (req.req_type == REQ_LOAD);
	assign is_flush = (req.req_type == REQ_FLUSH);

	assign len_sat = (req.code_len > LEN_IN_W'(MAX_CODE_LEN)) ?
		LEN_W'(MAX_CODE_LEN) : LEN_W'(req.code_len);

	hbp_ram #(
		.WIDTH(ENT_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (accept && is_load),
		.waddr(req.symbol),
		.wdata({req.code_bits, len_sat}),
		.re   (accept && is_enc),
		.raddr(req.symbol),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvld_q   <= '0;
			vld_s1   <= 1'b0;
			flush_s1 <= 1'b0;
			hit_s1   <= 1'b0;
		end else begin
			if (accept && is_load) begin
				tvld_q[req.symbol] <= 1'b1;
			end
			if (accept && (is_enc || is_flush)) begin
				vld_s1   <= 1'b1;
				flush_s1 <= is_flush;
				hit_s1   <= tvld_q[req.symbol];
			end else if (q_push) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	// entries never loaded read as length zero
	assign code_r  = rdata[ENT_W-1 -: CODE_W];
	assign len_r   = rdata[LEN_W-1:0];
	assign len_eff = hit_s1 ? len_r : '0;

	always_comb begin
		for (int i = 0; i < CODE_W; i++) begin
			mask[i] = (i < int'(len_eff));
		end
	end

	assign req_stall = vld_s1 && !q_ready;
	assign q_push    = vld_s1 && q_ready;
	assign q_data    = flush_s1 ? {1'b1, {ENT_W{1'b0}}} : {1'b0, code_r & mask, len_eff};

endmodule

### src/hbp_fifo.sv
module hbp_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         ready,
	input  logic         pop,
	output logic         valid,
	output logic [W-1:0] rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          full;

	assign full  = (cnt_q == CW'(DEPTH));
	assign ready = !full;
	assign valid = (cnt_q != '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid) else $error("pop from empty queue");

endmodule

### src/hbp_back.sv
module hbp_back #(
	parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  logic [hbp_pkg::CODE_W+$clog2(MAX_CODE_LEN+1):0] q_data,
	output logic          q_pop,
	output logic          rsp_valid,
	output hbp_pkg::rsp_t rsp,
	input  logic          rsp_stall
);

	import hbp_pkg::*;

	localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
	localparam int QW    = 1 + CODE_W + LEN_W;
	localparam int BUF_W = ((MAX_CODE_LEN + 14) / 8) * 8;
	localparam int CNT_W = $clog2(BUF_W + 1);
	localparam int SH_W  = $clog2(MAX_CODE_LEN + 8);

	logic              h_flush;
	logic [CODE_W-1:0] h_code;
	logic [LEN_W-1:0]  h_len;

	// bit accumulator: valid bits left-aligned, zeros below
	logic [BUF_W-1:0] wbuf_q;
	logic [CNT_W-1:0] wcnt_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic                     draining;
	logic [SH_W-1:0]          shamt;
	logic [CODE_W+BUF_W-1:0]  shifted;
	logic [BUF_W-1:0]         merged;
	logic [CNT_W-1:0]         mcnt;
	logic [BUF_W-1:0]         cbuf;
	logic [CNT_W-1:0]         ccnt;
	logic                     flush_now;
	logic                     need_out;
	logic                     out_free;
	logic                     go;
	logic                     emit;
	logic                     emit_last;
	logic [BYTE_W-1:0]        emit_byte;

	assign h_flush = q_data[QW-1];
	assign h_code  = q_data[LEN_W +: CODE_W];
	assign h_len   = q_data[LEN_W-1:0];

	assign draining = (wcnt_q >= CNT_W'(8));

	// place code bit len-1 right below the pending bits
	assign shamt   = SH_W'(wcnt_q[2:0]) + SH_W'(h_len);
	assign shifted = {h_code, {BUF_W{1'b0}}} >> shamt;
	assign merged  = wbuf_q | shifted[BUF_W-1:0];
	assign mcnt    = CNT_W'(wcnt_q[2:0]) + CNT_W'(h_len);

	assign cbuf = draining ? wbuf_q : merged;
	assign ccnt = draining ? wcnt_q : mcnt;

	assign flush_now = !draining && q_valid && h_flush;
	assign need_out  = flush_now ? (wcnt_q != '0) : (ccnt >= CNT_W'(8));
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign go        = (draining || q_valid) && (!need_out || out_free);
	assign q_pop     = !draining && q_valid && go;
	assign emit      = go && need_out;
	assign emit_last = flush_now || ((ccnt - CNT_W'(8)) < CNT_W'(8));
	assign emit_byte = flush_now ? wbuf_q[BUF_W-1 -: BYTE_W] : cbuf[BUF_W-1 -: BYTE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wbuf_q      <= '0;
			wcnt_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (go) begin
				if (flush_now) begin
					wbuf_q <= '0;
					wcnt_q <= '0;
				end else if (need_out) begin
					wbuf_q <= cbuf << BYTE_W;
					wcnt_q <= ccnt - CNT_W'(8);
				end else begin
					wbuf_q <= cbuf;
					wcnt_q <= ccnt;
				end
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q.out_byte <= emit_byte;
			rsp_q.last     <= emit_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_hold_queue_while_draining: assert property (@(posedge clk) disable iff (!arst_n)
		draining |-> !q_pop) else $error("queue popped with whole bytes still pending");

	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && h_flush) |=> (wcnt_q == '0)) else $error("flush left bits pending");

	a_more_bytes_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !emit_last) |=> draining) else $error("non-final beat without a following byte");

endmodule

### src/huffman_bit_packer.sv
// Path: an encode's bytes pass the registered table read, the queue and the rsp register before they reach rsp.
// Throughput: one request per cycle while req_stall is low; the table is read once per cycle through one RAM port.
// An encode that completes k bytes holds the back end until it has emitted all of them, one byte at a time;
// a four-entry queue between table lookup and packer absorbs those bursts.
// Reset: code table valid bits clear at once (all lengths zero), accumulator empty,
// no clearing pass; req_stall is low out of reset, so requests are taken at once.
module huffman_bit_packer #(
	parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  hbp_pkg::req_t req,
	output logic          req_stall,
	output logic          rsp_valid,
	output hbp_pkg::rsp_t rsp,
	input  logic          rsp_stall
);

	import hbp_pkg::*;

	localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
	localparam int QW    = 1 + CODE_W + LEN_W;

	logic          q_ready;
	logic          q_push;
	logic [QW-1:0] q_wdata;
	logic          q_valid;
	logic          q_pop;
	logic [QW-1:0] q_rdata;

	hbp_front #(
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req      (req),
		.req_stall(req_stall),
		.q_ready  (q_ready),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	hbp_fifo #(
		.W    (QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.ready (q_ready),
		.pop   (q_pop),
		.valid (q_valid),
		.rdata (q_rdata)
	);

	hbp_back #(
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_rdata),
		.q_pop    (q_pop),
		.rsp_valid(rsp_valid),
		.rsp      (rsp),
		.rsp_stall(rsp_stall)
	);

endmodule
